// File: sv/seven_segment_scan_driver_top_macros.svh
// Assertion macros shared by the seven-segment scan driver RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_TOP_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ssd_pkg.sv
// Shared types and constants for the seven-segment scan driver.
// No dependencies; used by ssd_loader and seven_segment_scan_driver_top.
`default_nettype none

package ssd_pkg;

    // Number of display positions held and scanned.
    localparam int DIGITS = 4;
    localparam int POS_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [POS_W-1:0] POS_LEFTMOST = POS_W'(DIGITS - 1);

    // Positions that a load fills with an encoded pattern.
    localparam int LOAD_DIGITS = 4;

    localparam int NUMBER_W = 14;
    localparam int CHAR_W   = 8;
    localparam int SEG_W    = 8;
    localparam int EN_W     = 4;
    localparam int DWELL_W  = 16;

    // Command codes carried in the input item's tuser.
    localparam logic [1:0] CMD_LOAD_NUMBER = 2'd0;
    localparam logic [1:0] CMD_LOAD_CHARS  = 2'd1;
    localparam logic [1:0] CMD_SCAN_TICK   = 2'd2;

    typedef logic [LOAD_DIGITS-1:0][SEG_W-1:0] t_load_patterns;

    typedef struct packed {
        logic                is_number;
        logic [NUMBER_W-1:0] number;
        logic [CHAR_W-1:0]   char_left;
        logic [CHAR_W-1:0]   char_mid_left;
        logic [CHAR_W-1:0]   char_mid_right;
        logic [CHAR_W-1:0]   char_right;
    } t_load_req;

endpackage

`default_nettype wire

// File: sv/ssd_loader.sv
// Turns a load request into four segment patterns (number split or character codes).
// Depends on ssd_pkg.
`default_nettype none

module ssd_loader (
    input  var ssd_pkg::t_load_req      i_req,
    output ssd_pkg::t_load_patterns     o_patterns
);

    localparam logic [ssd_pkg::NUMBER_W-1:0] MAX_SHOWN = 14'd9999;

    // Display codes understood besides the plain digits.
    localparam logic [7:0] CODE_A     = 8'd20;
    localparam logic [7:0] CODE_B     = 8'd30;
    localparam logic [7:0] CODE_C     = 8'd40;
    localparam logic [7:0] CODE_D     = 8'd50;
    localparam logic [7:0] CODE_E     = 8'd60;
    localparam logic [7:0] CODE_F     = 8'd70;
    localparam logic [7:0] CODE_H     = 8'd80;
    localparam logic [7:0] CODE_O     = 8'd90;
    localparam logic [7:0] CODE_L     = 8'd100;
    localparam logic [7:0] CODE_N     = 8'd110;
    localparam logic [7:0] CODE_U     = 8'd120;
    localparam logic [7:0] CODE_S     = 8'd130;
    localparam logic [7:0] CODE_T     = 8'd140;
    localparam logic [7:0] CODE_P     = 8'd150;
    localparam logic [7:0] CODE_DOT   = 8'd200;

    typedef struct packed {
        logic [3:0]                  digit;
        logic [ssd_pkg::NUMBER_W-1:0] rest;
    } t_split;

    // Picks the decimal digit at one weight by comparing against its nine multiples.
    function automatic t_split split_digit(input logic [ssd_pkg::NUMBER_W-1:0] value,
                                           input logic [ssd_pkg::NUMBER_W-1:0] weight);
        t_split                       res;
        logic [ssd_pkg::NUMBER_W-1:0] mult;
        res.digit = 4'd0;
        res.rest  = value;
        for (int k = 1; k <= 9; k++) begin
            mult = ssd_pkg::NUMBER_W'(k * weight);
            if (value >= mult) begin
                res.digit = 4'(k);
                res.rest  = value - mult;
            end
        end
        return res;
    endfunction

    // Segment order: bit 7 dot, bits 6..0 g..a. Unknown codes are blank.
    function automatic logic [ssd_pkg::SEG_W-1:0] encode(input logic [7:0] code);
        logic [ssd_pkg::SEG_W-1:0] seg;
        unique case (code)
            8'd0:     seg = 8'h3F;
            8'd1:     seg = 8'h06;
            8'd2:     seg = 8'h5B;
            8'd3:     seg = 8'h4F;
            8'd4:     seg = 8'h66;
            8'd5:     seg = 8'h6D;
            8'd6:     seg = 8'h7D;
            8'd7:     seg = 8'h07;
            8'd8:     seg = 8'h7F;
            8'd9:     seg = 8'h6F;
            CODE_A:   seg = 8'h77;
            CODE_B:   seg = 8'h7C;
            CODE_C:   seg = 8'h39;
            CODE_D:   seg = 8'h5E;
            CODE_E:   seg = 8'h79;
            CODE_F:   seg = 8'h71;
            CODE_H:   seg = 8'h76;
            CODE_O:   seg = 8'h3F;
            CODE_L:   seg = 8'h38;
            CODE_N:   seg = 8'h37;
            CODE_U:   seg = 8'h3E;
            CODE_S:   seg = 8'h6D;
            CODE_T:   seg = 8'h78;
            CODE_P:   seg = 8'h73;
            CODE_DOT: seg = 8'h80;
            default:  seg = 8'h00;
        endcase
        return seg;
    endfunction

    logic [ssd_pkg::NUMBER_W-1:0] sat_number;
    t_split                       split_th;
    t_split                       split_hu;
    t_split                       split_te;
    logic [3:0][7:0]              codes;

    always_comb begin
        sat_number = (i_req.number > MAX_SHOWN) ? MAX_SHOWN : i_req.number;
        split_th   = split_digit(sat_number, 14'd1000);
        split_hu   = split_digit(split_th.rest, 14'd100);
        split_te   = split_digit(split_hu.rest, 14'd10);

        if (i_req.is_number) begin
            codes[3] = {4'd0, split_th.digit};
            codes[2] = {4'd0, split_hu.digit};
            codes[1] = {4'd0, split_te.digit};
            codes[0] = split_te.rest[7:0];
        end else begin
            codes[3] = i_req.char_left;
            codes[2] = i_req.char_mid_left;
            codes[1] = i_req.char_mid_right;
            codes[0] = i_req.char_right;
        end

        for (int i = 0; i < ssd_pkg::LOAD_DIGITS; i++) begin
            o_patterns[i] = encode(codes[i]);
        end
    end

endmodule

`default_nettype wire

// File: sv/seven_segment_scan_driver_top.sv
// Top level of the multiplexed seven-segment scan driver.
// Depends on ssd_pkg, ssd_loader and seven_segment_scan_driver_top_macros.svh.
`default_nettype none
`include "seven_segment_scan_driver_top_macros.svh"

// Four-digit multiplexed seven-segment driver. Each input item carries a
// command in tuser: load number (the value, saturated to 9999, is split into
// decimal digits), load characters (four display codes, leftmost first) or
// scan tick. A load encodes and stores four segment patterns, restarts the scan
// at the leftmost digit and produces no output item. Each scan tick produces
// exactly one output item: an active-low one-hot digit enable (bit 3 leftmost)
// and that digit's segments (bit 7 dot, bits 6..0 g..a, 1 lit). The scan moves
// one digit to the right after dwell_ticks ticks (a dwell of zero acts as one)
// and wraps back to the leftmost digit; an unused command code is dropped.
// Items pass through an input register and a result register with a single
// level of decode, encode and scan logic between them, so the block accepts
// one item every clock cycle unless a stalled output holds it back. A tick
// is held in the input register, then in the result register, which offers
// its result on the output; a stalled output holds back further items only
// once the result register is full and the input register holds a tick.
// The dwell register is written through the configuration channel, which is
// always ready, and should be changed only while the block is idle. Reset
// leaves the display blank, the scan leftmost and the dwell at one tick.
module seven_segment_scan_driver_top (
    input  var logic        i_clk,
    input  var logic        i_rst_n,

    // Input items.
    input  var logic        s_axis_tvalid,
    output logic            s_axis_tready,
    // tdata, lowest bit up: number[13:0], char_left[21:14], char_mid_left[29:22],
    // char_mid_right[37:30], char_right[45:38], zero pad [47:46].
    input  var logic [47:0] s_axis_tdata,
    // tuser: cmd[1:0].
    input  var logic [1:0]  s_axis_tuser,

    // Output items.
    output logic            m_axis_tvalid,
    input  var logic        m_axis_tready,
    // tdata, lowest bit up: digit_enable[3:0], segments[11:4], zero pad [15:12].
    output logic [15:0]     m_axis_tdata,

    // Configuration: dwell_ticks.
    input  var logic        i_cfg_valid,
    output logic            o_cfg_ready,
    input  var logic [15:0] i_cfg_data
);

    localparam int DIG   = ssd_pkg::DIGITS;
    localparam int PW    = ssd_pkg::POS_W;
    localparam int DW    = ssd_pkg::DWELL_W;
    localparam int SW    = ssd_pkg::SEG_W;
    localparam int EW    = ssd_pkg::EN_W;

    // Input register.
    logic                 r_s1_valid;
    logic [1:0]           r_s1_cmd;
    ssd_pkg::t_load_req   r_s1_req;

    // Display state.
    logic [DIG-1:0][SW-1:0] r_patterns, n_patterns;
    logic [PW-1:0]          r_scan_pos, n_scan_pos;
    logic [DW-1:0]          r_dwell_count, n_dwell_count;
    logic [DW-1:0]          r_dwell_ticks;

    // Result register.
    logic                 r_out_valid, n_out_valid;
    logic [EW-1:0]        r_out_enable;
    logic [SW-1:0]        r_out_segments;

    ssd_pkg::t_load_patterns load_patterns;

    logic          s1_is_tick;
    logic          s1_is_load;
    logic          out_free;
    logic          s1_fire;
    logic [DW:0]   count_inc;
    logic [DW:0]   dwell_limit;
    logic [EW-1:0] tick_enable;

    assign s1_is_tick = (r_s1_cmd == ssd_pkg::CMD_SCAN_TICK);
    assign s1_is_load = (r_s1_cmd == ssd_pkg::CMD_LOAD_NUMBER)
                     || (r_s1_cmd == ssd_pkg::CMD_LOAD_CHARS);
    // A tick needs room in the result register; loads and unused codes never wait.
    assign out_free   = !r_out_valid || m_axis_tready;
    assign s1_fire    = r_s1_valid && (!s1_is_tick || out_free);

    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s1_cmd                <= s_axis_tuser;
            r_s1_req.is_number      <= (s_axis_tuser == ssd_pkg::CMD_LOAD_NUMBER);
            r_s1_req.number         <= s_axis_tdata[13:0];
            r_s1_req.char_left      <= s_axis_tdata[21:14];
            r_s1_req.char_mid_left  <= s_axis_tdata[29:22];
            r_s1_req.char_mid_right <= s_axis_tdata[37:30];
            r_s1_req.char_right     <= s_axis_tdata[45:38];
        end
    end

    ssd_loader u_loader (
        .i_req      (r_s1_req),
        .o_patterns (load_patterns)
    );

    // Dwell of zero counts as one tick.
    assign count_inc   = {1'b0, r_dwell_count} + (DW+1)'(1);
    assign dwell_limit = (r_dwell_ticks == '0) ? (DW+1)'(1) : {1'b0, r_dwell_ticks};

    // Positions beyond the four-bit select drive no digit.
    always_comb begin
        for (int b = 0; b < EW; b++) begin
            tick_enable[b] = (32'(r_scan_pos) != b);
        end
    end

    always_comb begin
        n_patterns    = r_patterns;
        n_scan_pos    = r_scan_pos;
        n_dwell_count = r_dwell_count;
        n_out_valid   = r_out_valid && !m_axis_tready;
        if (s1_fire) begin
            unique case (r_s1_cmd)
                ssd_pkg::CMD_LOAD_NUMBER,
                ssd_pkg::CMD_LOAD_CHARS: begin
                    for (int i = 0; i < DIG; i++) begin
                        n_patterns[i] = (i < ssd_pkg::LOAD_DIGITS)
                                      ? load_patterns[i] : '0;
                    end
                    n_scan_pos    = ssd_pkg::POS_LEFTMOST;
                    n_dwell_count = '0;
                end
                ssd_pkg::CMD_SCAN_TICK: begin
                    n_out_valid = 1'b1;
                    if (count_inc >= dwell_limit) begin
                        n_dwell_count = '0;
                        n_scan_pos    = (r_scan_pos == '0) ? ssd_pkg::POS_LEFTMOST
                                                           : r_scan_pos - PW'(1);
                    end else begin
                        n_dwell_count = count_inc[DW-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patterns    <= '0;
            r_scan_pos    <= ssd_pkg::POS_LEFTMOST;
            r_dwell_count <= '0;
            r_dwell_ticks <= DW'(1);
            r_out_valid   <= 1'b0;
        end else begin
            r_patterns    <= n_patterns;
            r_scan_pos    <= n_scan_pos;
            r_dwell_count <= n_dwell_count;
            r_out_valid   <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_dwell_ticks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_is_tick) begin
            r_out_enable   <= tick_enable;
            r_out_segments <= r_patterns[r_scan_pos];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_segments, r_out_enable};

    // A load always restarts the scan at the leftmost digit with a fresh dwell.
    `SSD_ASSERT_NEXT(a_load_restarts_scan, s1_fire && s1_is_load,
        r_scan_pos == ssd_pkg::POS_LEFTMOST && r_dwell_count == '0,
        "load did not restart the scan")

    // Every tick taken from the input register leaves a result behind it.
    `SSD_ASSERT_NEXT(a_tick_makes_result, s1_fire && s1_is_tick, r_out_valid,
        "scan tick produced no result")

    // A pending result is never overwritten by a tick while it is stalled.
    `SSD_ASSERT_SAME(a_no_overwrite, r_out_valid && !m_axis_tready && r_s1_valid
        && s1_is_tick, !s1_fire, "stalled result overwritten")

    // At most one digit is driven at a time.
    `SSD_ASSERT_SAME(a_one_digit_lit, r_out_valid, $onehot0(~r_out_enable),
        "more than one digit enabled")

endmodule

`default_nettype wire
